// ===== hw/rtl/ffa_pkg.sv =====
// Package for the first-fit extent allocator: status codes, field widths,
// microcode types and the microcode ROM. No dependencies.

package ffa_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int MAX_EXTENTS_DEF  = 16;

    localparam int SIZE_W   = 11;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_ZERO_SIZE  = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE   = 5'd0,
        S_DISP   = 5'd1,
        S_A_CHK  = 5'd2,
        S_A_RD0  = 5'd3,
        S_A_SCAN = 5'd4,
        S_A_TAIL = 5'd5,
        S_I_INIT = 5'd6,
        S_I_RD   = 5'd7,
        S_I_MV   = 5'd8,
        S_I_NEW  = 5'd9,
        S_F_SH   = 5'd10,
        S_F_MV   = 5'd11,
        S_F_END  = 5'd12,
        S_F_INIT = 5'd13,
        S_F_RD   = 5'd14,
        S_F_SCAN = 5'd15,
        S_DONE   = 5'd16
    } t_step;

    typedef enum logic [3:0] {
        A_NOP,
        A_LATCH,
        A_CHECK,
        A_RDNEXT,
        A_SCAN,
        A_TAIL,
        A_IINIT,
        A_IRD,
        A_IMV,
        A_INEW,
        A_FSH,
        A_FMV,
        A_FEND,
        A_FINIT,
        A_FSCAN,
        A_EMIT
    } t_act;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NOT_IN,
        C_IS_FREE,
        C_REJECT,
        C_EMPTY,
        C_FIT,
        C_NOT_LAST,
        C_LAST,
        C_TAIL_FIT,
        C_INS_END,
        C_UP_DONE,
        C_MATCH,
        C_DN_DONE,
        C_OUT_BUSY
    } t_cond;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_fire;
        logic is_free;
        logic reject;
        logic empty;
        logic fit;
        logic last;
        logic tail_fit;
        logic ins_end;
        logic up_done;
        logic match;
        logic dn_done;
        logic out_busy;
    } t_flags;

    // One control word: action, then two prioritized jumps, else fall through
    typedef struct packed {
        t_act  act;
        t_cond c1;
        t_step t1;
        t_cond c2;
        t_step t2;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{act: A_NOP, c1: C_ALWAYS, t1: S_IDLE, c2: C_NONE, t2: S_IDLE};
        unique case (s)
            S_IDLE:   w = '{A_LATCH,  C_NOT_IN,   S_IDLE,   C_NONE,     S_IDLE};
            S_DISP:   w = '{A_NOP,    C_IS_FREE,  S_F_INIT, C_NONE,     S_IDLE};
            S_A_CHK:  w = '{A_CHECK,  C_REJECT,   S_DONE,   C_EMPTY,    S_I_NEW};
            S_A_RD0:  w = '{A_RDNEXT, C_NONE,     S_IDLE,   C_NONE,     S_IDLE};
            S_A_SCAN: w = '{A_SCAN,   C_FIT,      S_I_INIT, C_NOT_LAST, S_A_SCAN};
            S_A_TAIL: w = '{A_TAIL,   C_TAIL_FIT, S_I_INIT, C_ALWAYS,   S_DONE};
            S_I_INIT: w = '{A_IINIT,  C_INS_END,  S_I_NEW,  C_NONE,     S_IDLE};
            S_I_RD:   w = '{A_IRD,    C_NONE,     S_IDLE,   C_NONE,     S_IDLE};
            S_I_MV:   w = '{A_IMV,    C_UP_DONE,  S_I_NEW,  C_ALWAYS,   S_I_MV};
            S_I_NEW:  w = '{A_INEW,   C_ALWAYS,   S_DONE,   C_NONE,     S_IDLE};
            S_F_SH:   w = '{A_FSH,    C_LAST,     S_F_END,  C_NONE,     S_IDLE};
            S_F_MV:   w = '{A_FMV,    C_DN_DONE,  S_F_END,  C_ALWAYS,   S_F_MV};
            S_F_END:  w = '{A_FEND,   C_ALWAYS,   S_DONE,   C_NONE,     S_IDLE};
            S_F_INIT: w = '{A_FINIT,  C_EMPTY,    S_DONE,   C_NONE,     S_IDLE};
            S_F_RD:   w = '{A_RDNEXT, C_NONE,     S_IDLE,   C_NONE,     S_IDLE};
            S_F_SCAN: w = '{A_FSCAN,  C_MATCH,    S_F_SH,   C_NOT_LAST, S_F_SCAN};
            S_DONE:   w = '{A_EMIT,   C_OUT_BUSY, S_DONE,   C_ALWAYS,   S_IDLE};
            default:  w = '{A_NOP,    C_ALWAYS,   S_IDLE,   C_NONE,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ffa_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on ffa_pkg.

module ffa_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffa_pkg::t_flags i_flags,
    output ffa_pkg::t_uword o_uword
);

    ffa_pkg::t_step  r_upc;
    ffa_pkg::t_step  n_upc;
    ffa_pkg::t_uword uw;

    function automatic logic cond_true(input ffa_pkg::t_cond c, input ffa_pkg::t_flags f);
        logic v;
        v = 1'b0;
        unique case (c)
            ffa_pkg::C_NONE:     v = 1'b0;
            ffa_pkg::C_ALWAYS:   v = 1'b1;
            ffa_pkg::C_NOT_IN:   v = !f.in_fire;
            ffa_pkg::C_IS_FREE:  v = f.is_free;
            ffa_pkg::C_REJECT:   v = f.reject;
            ffa_pkg::C_EMPTY:    v = f.empty;
            ffa_pkg::C_FIT:      v = f.fit;
            ffa_pkg::C_NOT_LAST: v = !f.last;
            ffa_pkg::C_LAST:     v = f.last;
            ffa_pkg::C_TAIL_FIT: v = f.tail_fit;
            ffa_pkg::C_INS_END:  v = f.ins_end;
            ffa_pkg::C_UP_DONE:  v = f.up_done;
            ffa_pkg::C_MATCH:    v = f.match;
            ffa_pkg::C_DN_DONE:  v = f.dn_done;
            ffa_pkg::C_OUT_BUSY: v = f.out_busy;
            default:             v = 1'b0;
        endcase
        return v;
    endfunction

    assign uw      = ffa_pkg::ucode(r_upc);
    assign o_uword = uw;

    always_comb begin
        priority if (cond_true(uw.c1, i_flags)) begin
            n_upc = uw.t1;
        end else if (cond_true(uw.c2, i_flags)) begin
            n_upc = uw.t2;
        end else begin
            n_upc = ffa_pkg::t_step'(r_upc + 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= ffa_pkg::S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== hw/rtl/first_fit_extent_allocator.sv =====
// First-fit extent allocator top level: datapath, extent table RAM and sequencer.
// Depends on ffa_pkg, ffa_ram and ffa_seq.
//
// Handles one request at a time. The time an allocate or a free takes grows with n + m,
// where n is the number of table entries scanned and m the number of entries moved to
// open or close a slot. Only the entries above the hit move, so n + m stays within
// MAX_EXTENTS. The extent table is a RAM with one read and one write port, so the
// microcode visits one entry per cycle. Rejected requests go from the check straight to
// the result. A new request is taken while the previous result waits on the master side;
// the result register then holds until it is taken, and a stalled master side adds its
// stall to the next request.

module first_fit_extent_allocator #(
    parameter int BUFFER_BYTES = ffa_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_EXTENTS  = ffa_pkg::MAX_EXTENTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [10:0] req_size, [20:11] req_addr, [23:21] zero
    input  logic [ffa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] status, [12:3] grant_addr, [23:13] free_bytes
    output logic [ffa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW   = $clog2(BUFFER_BYTES);
    localparam int SW   = $clog2(BUFFER_BYTES + 1);
    localparam int CW   = ((SW > ffa_pkg::SIZE_W) ? SW : ffa_pkg::SIZE_W) + 1;
    localparam int IW   = $clog2(MAX_EXTENTS);
    localparam int CNTW = $clog2(MAX_EXTENTS + 1);
    localparam int EW   = AW + SW;

    ffa_pkg::t_uword uw;
    ffa_pkg::t_flags flags;

    // request
    logic                      r_op;
    logic [CW-1:0]             r_size;
    logic [ffa_pkg::ADDR_W-1:0] r_addr;
    logic                      n_op;
    logic [CW-1:0]             n_size;
    logic [ffa_pkg::ADDR_W-1:0] n_addr;

    // allocator state
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [SW-1:0]   r_free, n_free;

    // work registers
    logic [CNTW-1:0]      r_idx, n_idx;
    logic [CNTW-1:0]      r_ins, n_ins;
    logic [IW-1:0]        r_wa, n_wa;
    logic [CW-1:0]        r_prev_end, n_prev_end;
    logic [CW-1:0]        r_grant, n_grant;
    ffa_pkg::t_status     r_status, n_status;

    // result register
    logic                          r_out_valid, n_out_valid;
    ffa_pkg::t_status              r_o_status, n_o_status;
    logic [ffa_pkg::ADDR_W-1:0]    r_o_grant, n_o_grant;
    logic [ffa_pkg::FREE_W-1:0]    r_o_free, n_o_free;

    // table RAM
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;
    logic [AW-1:0] rd_start;
    logic [SW-1:0] rd_len;
    logic [CW-1:0] rd_start_c;
    logic [CW-1:0] rd_end;
    logic [CW-1:0] need_end;
    logic [CW-1:0] free_c;
    logic          in_fire;
    logic          zero_size;
    logic          no_space;
    logic          full;

    ffa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    ffa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EXTENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // table entry: start in the high bits, length in the low bits
    assign rd_start   = ram_rdata[EW-1:SW];
    assign rd_len     = ram_rdata[SW-1:0];
    assign rd_start_c = CW'(rd_start);
    assign rd_end     = CW'(rd_start) + CW'(rd_len);
    assign need_end   = r_prev_end + r_size;
    assign free_c     = CW'(r_free);

    assign s_axis_tready = (uw.act == ffa_pkg::A_LATCH) && i_rst_n;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign zero_size = (r_size == '0);
    assign no_space  = (r_size > free_c);
    assign full      = (r_cnt == CNTW'(MAX_EXTENTS));

    always_comb begin
        flags.in_fire  = in_fire;
        flags.is_free  = r_op;
        flags.reject   = zero_size || no_space || full;
        flags.empty    = (r_cnt == '0);
        // gap between entry r_idx-2 and entry r_idx-1 (now on the read port)
        flags.fit      = (r_idx >= CNTW'(2)) && (rd_start_c >= need_end);
        flags.last     = (r_idx == r_cnt);
        flags.tail_fit = (CW'(BUFFER_BYTES) >= need_end);
        flags.ins_end  = (r_ins == r_cnt);
        // last move writes the slot just above the insert point
        flags.up_done  = (CNTW'(r_wa) == (r_ins + CNTW'(1)));
        flags.match    = (rd_start_c == CW'(r_addr));
        flags.dn_done  = ((CNTW'(r_wa) + CNTW'(2)) == r_cnt);
        flags.out_busy = r_out_valid && !m_axis_tready;
    end

    always_comb begin
        n_op        = r_op;
        n_size      = r_size;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_free      = r_free;
        n_idx       = r_idx;
        n_ins       = r_ins;
        n_wa        = r_wa;
        n_prev_end  = r_prev_end;
        n_grant     = r_grant;
        n_status    = r_status;
        n_o_status  = r_o_status;
        n_o_grant   = r_o_grant;
        n_o_free    = r_o_free;
        n_out_valid = r_out_valid && !m_axis_tready;
        ram_we      = 1'b0;
        ram_waddr   = r_wa;
        ram_wdata   = ram_rdata;

        unique case (uw.act)
            ffa_pkg::A_NOP: begin
            end
            ffa_pkg::A_LATCH: begin
                if (in_fire) begin
                    n_op   = s_axis_tuser[0];
                    n_size = CW'(s_axis_tdata[ffa_pkg::SIZE_W-1:0]);
                    n_addr = s_axis_tdata[ffa_pkg::SIZE_W +: ffa_pkg::ADDR_W];
                end
            end
            ffa_pkg::A_CHECK: begin
                n_grant = '0;
                n_ins   = '0;
                n_idx   = '0;
                priority if (zero_size) begin
                    n_status = ffa_pkg::ST_ZERO_SIZE;
                end else if (no_space) begin
                    n_status = ffa_pkg::ST_NO_SPACE;
                end else if (full) begin
                    n_status = ffa_pkg::ST_TABLE_FULL;
                end else begin
                    n_status = ffa_pkg::ST_OK;
                end
            end
            ffa_pkg::A_RDNEXT: begin
                n_idx = r_idx + CNTW'(1);
            end
            ffa_pkg::A_SCAN: begin
                if (flags.fit) begin
                    n_ins   = r_idx - CNTW'(1);
                    n_grant = r_prev_end;
                end else begin
                    n_prev_end = rd_end;
                    n_idx      = r_idx + CNTW'(1);
                end
            end
            ffa_pkg::A_TAIL: begin
                if (flags.tail_fit) begin
                    n_ins   = r_cnt;
                    n_grant = r_prev_end;
                end else begin
                    n_status = ffa_pkg::ST_NO_SPACE;
                end
            end
            ffa_pkg::A_IINIT: begin
                n_idx = r_cnt - CNTW'(1);
            end
            ffa_pkg::A_IRD: begin
                n_wa  = r_idx[IW-1:0] + IW'(1);
                n_idx = r_idx - CNTW'(1);
            end
            ffa_pkg::A_IMV: begin
                // move entry r_wa-1 up one slot, read the next one down
                ram_we = 1'b1;
                if (!flags.up_done) begin
                    n_wa  = r_idx[IW-1:0] + IW'(1);
                    n_idx = r_idx - CNTW'(1);
                end
            end
            ffa_pkg::A_INEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_ins[IW-1:0];
                ram_wdata = {r_grant[AW-1:0], r_size[SW-1:0]};
                n_cnt     = r_cnt + CNTW'(1);
                n_free    = r_free - r_size[SW-1:0];
                n_status  = ffa_pkg::ST_OK;
            end
            ffa_pkg::A_FINIT: begin
                n_status = ffa_pkg::ST_NOT_FOUND;
                n_grant  = '0;
                n_idx    = '0;
            end
            ffa_pkg::A_FSCAN: begin
                if (flags.match) begin
                    n_ins  = r_idx - CNTW'(1);
                    n_free = r_free + rd_len;
                end else begin
                    n_idx = r_idx + CNTW'(1);
                end
            end
            ffa_pkg::A_FSH: begin
                n_wa  = r_idx[IW-1:0] - IW'(1);
                n_idx = r_idx + CNTW'(1);
            end
            ffa_pkg::A_FMV: begin
                // move entry r_wa+1 down one slot
                ram_we = 1'b1;
                n_wa   = r_wa + IW'(1);
                n_idx  = r_idx + CNTW'(1);
            end
            ffa_pkg::A_FEND: begin
                n_cnt    = r_cnt - CNTW'(1);
                n_status = ffa_pkg::ST_OK;
            end
            ffa_pkg::A_EMIT: begin
                if (!flags.out_busy) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_grant   = r_grant[ffa_pkg::ADDR_W-1:0];
                    n_o_free    = free_c[ffa_pkg::FREE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_free      <= SW'(BUFFER_BYTES);
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_size     <= n_size;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_ins      <= n_ins;
        r_wa       <= n_wa;
        r_prev_end <= n_prev_end;
        r_grant    <= n_grant;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_grant  <= n_o_grant;
        r_o_free   <= n_o_free;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_o_free, r_o_grant, r_o_status};

endmodule

// ===== verif/ffa_checker.sv =====
// Request/reply word layouts and the checker for the first-fit extent allocator.
// The checker keeps its own copy of the extent table, predicts every reply and compares.
// Depends on ffa_pkg.

package ffa_req_pkg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_req_op;

    // tdata of a request beat: size in the low bits
    typedef struct packed {
        logic [2:0]                 pad;
        logic [ffa_pkg::ADDR_W-1:0] addr;
        logic [ffa_pkg::SIZE_W-1:0] size;
    } t_req_word;

    // tdata of a reply beat: status in the low bits
    typedef struct packed {
        logic [ffa_pkg::FREE_W-1:0] free_bytes;
        logic [ffa_pkg::ADDR_W-1:0] grant_addr;
        ffa_pkg::t_status           status;
    } t_reply_word;

endpackage

module ffa_checker #(
    parameter int BUFFER_BYTES = ffa_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_EXTENTS  = ffa_pkg::MAX_EXTENTS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            s_axis_tvalid,
    input  logic                                            s_axis_tready,
    input  logic [ffa_pkg::IN_TDATA_W-1:0]                  s_axis_tdata,
    input  logic [0:0]                                      s_axis_tuser,
    input  logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    input  logic [ffa_pkg::OUT_TDATA_W-1:0]                 m_axis_tdata,
    output int                                              o_errors,
    output int                                              o_pending,
    output int                                              o_live_count,
    output logic [MAX_EXTENTS-1:0][ffa_pkg::ADDR_W-1:0]     o_live_start,
    output logic [4:0][15:0]                                o_status_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;
    import ffa_req_pkg::*;

    logic [ADDR_W-1:0] ext_start [MAX_EXTENTS];
    logic [SIZE_W-1:0] ext_len   [MAX_EXTENTS];
    int                ext_count;
    int                bytes_free;
    int                err_cnt;
    logic [4:0][15:0]  hits;
    t_reply_word       replies_due [$];

    initial begin
        o_errors      = 0;
        o_pending     = 0;
        o_live_count  = 0;
        o_live_start  = '0;
        o_status_hits = '0;
        err_cnt       = 0;
        hits          = '0;
    end

    // First fit, searching only the gaps that follow an extent
    function automatic t_reply_word place_extent(input int size);
        t_reply_word r;
        int          i;
        int          j;
        int          gap_lo;
        int          gap_hi;
        bit          placed;
        r = '{free_bytes: '0, grant_addr: '0, status: ST_OK};
        if (size == 0) begin
            r.status = ST_ZERO_SIZE;
        end else if (size > bytes_free) begin
            r.status = ST_NO_SPACE;
        end else if (ext_count >= MAX_EXTENTS) begin
            r.status = ST_TABLE_FULL;
        end else if (ext_count == 0) begin
            ext_start[0] = '0;
            ext_len[0]   = SIZE_W'(size);
            ext_count    = 1;
            bytes_free   = bytes_free - size;
        end else begin
            placed = 1'b0;
            for (i = 0; i < ext_count && !placed; i++) begin
                gap_lo = int'(ext_start[i]) + int'(ext_len[i]);
                gap_hi = (i + 1 < ext_count) ? int'(ext_start[i+1]) : BUFFER_BYTES;
                if (gap_hi >= gap_lo && gap_hi - gap_lo >= size) begin
                    for (j = ext_count; j > i + 1; j--) begin
                        ext_start[j] = ext_start[j-1];
                        ext_len[j]   = ext_len[j-1];
                    end
                    ext_start[i+1] = ADDR_W'(gap_lo);
                    ext_len[i+1]   = SIZE_W'(size);
                    ext_count      = ext_count + 1;
                    bytes_free     = bytes_free - size;
                    r.grant_addr   = ADDR_W'(gap_lo);
                    placed         = 1'b1;
                end
            end
            if (!placed) r.status = ST_NO_SPACE;
        end
        r.free_bytes = FREE_W'(bytes_free);
        return r;
    endfunction

    function automatic t_reply_word drop_extent(input logic [ADDR_W-1:0] addr);
        t_reply_word r;
        int          i;
        int          j;
        bit          found;
        r = '{free_bytes: '0, grant_addr: '0, status: ST_NOT_FOUND};
        found = 1'b0;
        for (i = 0; i < ext_count && !found; i++) begin
            if (ext_start[i] == addr) begin
                bytes_free = bytes_free + int'(ext_len[i]);
                for (j = i; j + 1 < ext_count; j++) begin
                    ext_start[j] = ext_start[j+1];
                    ext_len[j]   = ext_len[j+1];
                end
                ext_count = ext_count - 1;
                r.status  = ST_OK;
                found     = 1'b1;
            end
        end
        r.free_bytes = FREE_W'(bytes_free);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_req_word   req;
        t_reply_word want;
        t_reply_word got;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_EXTENTS; k++) begin
                ext_start[k] = '0;
                ext_len[k]   = '0;
            end
            ext_count  = 0;
            bytes_free = BUFFER_BYTES;
            replies_due.delete();
        end else begin
            // reply side first: a reply never belongs to a request taken at the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_reply_word'(m_axis_tdata);
                if (replies_due.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected reply beat %h", $time, m_axis_tdata);
                end else begin
                    want = replies_due.pop_front();
                    if (got.status <= ST_ZERO_SIZE) hits[got.status] = hits[got.status] + 1;
                    if (got.status !== want.status) begin
                        err_cnt++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.grant_addr !== want.grant_addr) begin
                        err_cnt++;
                        $display("%0t: grant_addr expected %0d got %0d",
                                 $time, want.grant_addr, got.grant_addr);
                    end
                    if (got.free_bytes !== want.free_bytes) begin
                        err_cnt++;
                        $display("%0t: free_bytes expected %0d got %0d",
                                 $time, want.free_bytes, got.free_bytes);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req = t_req_word'(s_axis_tdata);
                if (t_req_op'(s_axis_tuser[0]) == OP_ALLOC) replies_due.push_back(place_extent(int'(req.size)));
                else replies_due.push_back(drop_extent(req.addr));
            end
        end
        o_errors      <= err_cnt;
        o_pending     <= replies_due.size();
        o_live_count  <= ext_count;
        o_status_hits <= hits;
        for (int k = 0; k < MAX_EXTENTS; k++) o_live_start[k] <= ext_start[k];
    end

endmodule

// ===== verif/first_fit_extent_allocator_tb.sv =====
// Top of the first-fit extent allocator testbench: clock, reset, request and reply
// stimulus with random idle bursts, watchdog and verdict. Depends on ffa_pkg, ffa_req_pkg,
// ffa_checker and first_fit_extent_allocator.

module first_fit_extent_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;
    import ffa_req_pkg::*;

    localparam int BUFFER_BYTES = 1024;
    localparam int MAX_EXTENTS  = 16;
    localparam int RANDOM_ITEMS = 1390;
    localparam int CALM_TAIL    = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 50;

    typedef enum int {
        MIX_FILL,
        MIX_CHURN,
        MIX_DRAIN
    } t_mix;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int                                  errors;
    int                                  pending;
    int                                  live_count;
    logic [MAX_EXTENTS-1:0][ADDR_W-1:0]  live_start;
    logic [4:0][15:0]                    status_hits;

    bit calm = 1'b0;
    int hold = 0;
    int quiet_cycles = 0;
    int sent = 0;

    always #5 i_clk = ~i_clk;

    first_fit_extent_allocator #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MAX_EXTENTS (MAX_EXTENTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    ffa_checker #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_ffa_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_live_count (live_count),
        .o_live_start (live_start),
        .o_status_hits(status_hits)
    );

    // Reply side backpressure: random low bursts between ready stretches, always ready while calm
    always @(negedge i_clk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (hold > 0) begin
            hold <= hold - 1;
        end else if (m_axis_tready && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            hold          <= $urandom_range(0, 14);
        end else begin
            m_axis_tready <= 1'b1;
            hold          <= $urandom_range(0, 30);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d replies outstanding",
                     $time, IDLE_LIMIT, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken
    task automatic issue(input t_req_op op, input int size, input int addr);
        int gap;
        if (!calm && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, ADDR_W'(addr), SIZE_W'(size)};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
        sent++;
    endtask

    // Mostly a start that is live right now, sometimes any address
    function automatic int pick_free_addr();
        if (live_count > 0 && $urandom_range(0, 99) < 85)
            return int'(live_start[$urandom_range(0, live_count - 1)]);
        return $urandom_range(0, BUFFER_BYTES - 1);
    endfunction

    function automatic int pick_size(input t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 0;
        if (mix == MIX_FILL) return $urandom_range(1, 24);
        if (r < 9) return BUFFER_BYTES;
        if (r < 25) return $urandom_range(65, BUFFER_BYTES - 1);
        return $urandom_range(1, 64);
    endfunction

    initial begin
        t_mix mix;
        int   run_len;
        int   free_pct;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        issue(OP_FREE,  $urandom_range(0, 1024), 0);              // free on empty table
        issue(OP_ALLOC, 0, $urandom_range(0, 1023));              // zero size
        issue(OP_ALLOC, BUFFER_BYTES, 1023);                      // whole buffer
        issue(OP_ALLOC, 1, 0);                                    // short of bytes
        issue(OP_FREE,  1024, 5);                                 // unknown address
        issue(OP_FREE,  0, 0);
        issue(OP_ALLOC, 512, 1023);
        issue(OP_ALLOC, 512, 0);
        issue(OP_FREE,  2, 0);
        issue(OP_ALLOC, 100, 0);                                  // only the gap before first
        issue(OP_FREE,  0, 512);
        issue(OP_ALLOC, 1023, 0);
        issue(OP_ALLOC, 1, 1023);                                 // last byte of the tail
        issue(OP_FREE,  1023, 1023);
        issue(OP_FREE,  1023, 1023);                              // already gone
        issue(OP_FREE,  0, 0);
        for (int k = 0; k <= MAX_EXTENTS; k++)                    // last one hits table full
            issue(OP_ALLOC, 1, $urandom_range(0, 1023));

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mix     = t_mix'($urandom_range(0, 2));
            run_len = $urandom_range(20, 60);
            calm    = (sent >= RANDOM_ITEMS - CALM_TAIL) || ($urandom_range(0, 3) == 0);
            free_pct = (mix == MIX_FILL) ? 15 : (mix == MIX_CHURN) ? 50 : 85;
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 99) < free_pct)
                    issue(OP_FREE, $urandom_range(0, BUFFER_BYTES), pick_free_addr());
                else
                    issue(OP_ALLOC, pick_size(mix), $urandom_range(0, BUFFER_BYTES - 1));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d replies checked: %0d ok, %0d no space, %0d table full, %0d unknown addr, %0d zero size",
                 status_hits[ST_OK] + status_hits[ST_NO_SPACE] + status_hits[ST_TABLE_FULL]
                 + status_hits[ST_NOT_FOUND] + status_hits[ST_ZERO_SIZE],
                 status_hits[ST_OK], status_hits[ST_NO_SPACE], status_hits[ST_TABLE_FULL],
                 status_hits[ST_NOT_FOUND], status_hits[ST_ZERO_SIZE]);
        $display("fill/churn/drain request mixes with idle bursts on both channels");
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
